// ===== src/dbbr_pkg.sv =====
// shared types and constants for the debounced blink-rate control block
// no dependencies
`default_nettype none

package dbbr_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned THRESH_W = 8;
  localparam int unsigned STEP_W   = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX       = 2'd3;

  localparam logic [THRESH_W-1:0] RST_THRESHOLD = 8'd5;
  localparam logic [STEP_W-1:0]   RST_STEP      = 10'd50;
  localparam logic [PERIOD_W-1:0] RST_MIN       = 16'd50;
  localparam logic [PERIOD_W-1:0] RST_MAX       = 16'd2000;
  localparam logic [PERIOD_W-1:0] RST_PERIOD    = 16'd500;
  localparam logic [PERIOD_W-1:0] PERIOD_SAT    = 16'hFFFF;

  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic [PERIOD_W-1:0] min_p;
    logic [PERIOD_W-1:0] max_p;
  } period_cfg_t;

  typedef struct packed {
    logic up;
    logic down;
  } press_t;

endpackage

`default_nettype wire

// ===== src/dbbr_debounce.sv =====
// debouncer for one active-low button: stable level, run counter, press detect
// depends on dbbr_pkg
`default_nettype none

module dbbr_debounce
  import dbbr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                raw,
  input  wire logic [THRESH_W-1:0] threshold,
  output logic                     press
);

  logic                stable;
  logic                stable_next;
  logic [THRESH_W-1:0] count;
  logic [THRESH_W-1:0] count_next;
  logic [THRESH_W-1:0] count_inc;

  assign count_inc = count + THRESH_W'(1);

  always_comb begin
    stable_next = stable;
    count_next  = count_inc;
    press       = 1'b0;
    if (raw == stable) begin
      count_next = '0;
    end else if (count_inc >= threshold) begin
      stable_next = raw;
      count_next  = '0;
      press       = ~raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b1;
      count  <= '0;
    end else if (step) begin
      stable <= stable_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/dbbr_blink.sv =====
// blink tick counter, led toggle and period adjust on button presses
// depends on dbbr_pkg
`default_nettype none

module dbbr_blink
  import dbbr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire press_t              press,
  input  wire period_cfg_t         cfg,
  output logic                     led_next,
  output logic [PERIOD_W-1:0]      period_next
);

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] tick_count;
  logic [PERIOD_W-1:0] tick_count_next;
  logic [PERIOD_W-1:0] tick_inc;
  logic                led;
  logic [PERIOD_W-1:0] step_ext;
  logic [PERIOD_W-1:0] period_up;
  logic [PERIOD_W:0]   period_sum;

  assign step_ext = PERIOD_W'(cfg.step);
  assign tick_inc = (tick_count == PERIOD_SAT) ? tick_count : tick_count + PERIOD_W'(1);

  always_comb begin
    tick_count_next = tick_inc;
    led_next        = led;
    if (tick_inc >= period) begin
      tick_count_next = '0;
      led_next        = ~led;
    end
  end

  // up press first, then down press on the shortened value
  always_comb begin
    period_up = period;
    if (press.up && (period > cfg.min_p)) begin
      period_up = (step_ext > period) ? '0 : period - step_ext;
    end
    period_sum  = {1'b0, period_up} + {1'b0, step_ext};
    period_next = period_up;
    if (press.down && (period_up < cfg.max_p)) begin
      period_next = period_sum[PERIOD_W] ? PERIOD_SAT : period_sum[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= RST_PERIOD;
      tick_count <= '0;
      led        <= 1'b0;
    end else if (step) begin
      period     <= period_next;
      tick_count <= tick_count_next;
      led        <= led_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/debounced_button_blink_rate_control.sv =====
// top level: input register, config registers, debouncers, blink logic, result register
// an accepted beat passes the input register, then the result register, to out_valid
// throughput: one beat per cycle; input stalls only while a held result is stalled
// reset: synchronous, clears both stages, restores config defaults and blink state
// depends on dbbr_pkg, dbbr_debounce, dbbr_blink
`default_nettype none

module debounced_button_blink_rate_control
  import dbbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  up_raw_level,
  input  wire logic                  down_raw_level,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       led_level,
  output logic [PERIOD_W-1:0]        current_period,
  output logic                       up_pressed,
  output logic                       down_pressed,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                in_full;
  logic                up_q;
  logic                down_q;
  logic                advance;
  logic                step;
  logic [THRESH_W-1:0] threshold;
  period_cfg_t         pcfg;
  press_t              press;
  logic                led_next;
  logic [PERIOD_W-1:0] period_next;

  assign advance  = ~out_valid | ~out_stall;
  assign step     = in_full & advance;
  assign in_stall = in_full & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= RST_THRESHOLD;
      pcfg.step  <= RST_STEP;
      pcfg.min_p <= RST_MIN;
      pcfg.max_p <= RST_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold  <= cfg_data[THRESH_W-1:0];
        REG_STEP:      pcfg.step  <= cfg_data[STEP_W-1:0];
        REG_MIN:       pcfg.min_p <= cfg_data[PERIOD_W-1:0];
        REG_MAX:       pcfg.max_p <= cfg_data[PERIOD_W-1:0];
        default:       threshold  <= threshold;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      up_q   <= up_raw_level;
      down_q <= down_raw_level;
    end
  end

  dbbr_debounce u_up_deb (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .raw       (up_q),
    .threshold (threshold),
    .press     (press.up)
  );

  dbbr_debounce u_down_deb (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .raw       (down_q),
    .threshold (threshold),
    .press     (press.down)
  );

  dbbr_blink u_blink (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .press       (press),
    .cfg         (pcfg),
    .led_next    (led_next),
    .period_next (period_next)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      led_level      <= led_next;
      current_period <= period_next;
      up_pressed     <= press.up;
      down_pressed   <= press.down;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_beat_kept: assert property (@(posedge clk) disable iff (rst)
    in_full && out_valid && out_stall |=> in_full)
    else $error("input beat lost while result stalled");

  a_period_only_on_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(current_period) && $stable(led_level))
    else $error("result fields changed without a step");

  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("step did not load a result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_full)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== test/debounced_button_blink_rate_control_tb.sv =====
// testbench for debounced_button_blink_rate_control: random button ticks, blink/period predictor
// queued driver and checking monitor as clocked blocks; depends on dbbr_pkg and the block itself
`default_nettype none

module debounced_button_blink_rate_control_tb;
  import dbbr_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic up;
    logic down;
  } buttons_t;

  typedef struct packed {
    logic                led;
    logic [PERIOD_W-1:0] period;
    logic                up_p;
    logic                down_p;
  } blink_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  up_raw_level = 1'b1;
  logic                  down_raw_level = 1'b1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  led_level;
  logic [PERIOD_W-1:0]   current_period;
  logic                  up_pressed;
  logic                  down_pressed;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  buttons_t tick_q[$];
  blink_t   blink_q[$];
  logic     in_taken = 1'b0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_trig = 1'b0;
  bit       hold_seen = 1'b0;
  int       hold_left = 0;
  int       errors = 0;
  int       cycles = 0;

  // predictor state and its copy of the registers
  logic [THRESH_W-1:0] thr_cfg;
  logic [STEP_W-1:0]   step_cfg;
  logic [PERIOD_W-1:0] min_cfg;
  logic [PERIOD_W-1:0] max_cfg;
  logic [PERIOD_W-1:0] period_cur;
  logic [PERIOD_W-1:0] tick_cnt;
  logic                led_cur;
  logic                stable_lvl[2];
  logic [THRESH_W-1:0] bounce_cnt[2];

  debounced_button_blink_rate_control dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic settle(int b, logic raw);
    if (raw == stable_lvl[b]) begin
      bounce_cnt[b] = '0;
      return 1'b0;
    end
    bounce_cnt[b] = bounce_cnt[b] + 1'b1;
    if (bounce_cnt[b] >= thr_cfg) begin
      stable_lvl[b] = raw;
      bounce_cnt[b] = '0;
      return raw == 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic blink_t next_blink(logic up_raw, logic down_raw);
    blink_t r;
    int     p;
    if (tick_cnt < PERIOD_SAT) tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= period_cur) begin
      tick_cnt = '0;
      led_cur = ~led_cur;
    end
    r.up_p = settle(0, up_raw);
    p = period_cur;
    if (r.up_p && period_cur > min_cfg) p = (step_cfg > p) ? 0 : p - step_cfg;
    period_cur = p[PERIOD_W-1:0];
    r.down_p = settle(1, down_raw);
    if (r.down_p && period_cur < max_cfg) begin
      p = p + step_cfg;
      if (p > 65535) p = 65535;
    end
    period_cur = p[PERIOD_W-1:0];
    r.led = led_cur;
    r.period = period_cur;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      up_raw_level <= tick_q[0].up;
      down_raw_level <= tick_q[0].down;
      void'(tick_q.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 80;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    blink_t e;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) blink_q.push_back(next_blink(up_raw_level, down_raw_level));
      if (out_valid && !out_stall) begin
        if (blink_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = blink_q.pop_front();
          if (led_level !== e.led) begin
            $error("led_level expected %0d got %0d", e.led, led_level);
            errors++;
          end
          if (current_period !== e.period) begin
            $error("current_period expected %0d got %0d", e.period, current_period);
            errors++;
          end
          if (up_pressed !== e.up_p) begin
            $error("up_pressed expected %0d got %0d", e.up_p, up_pressed);
            errors++;
          end
          if (down_pressed !== e.down_p) begin
            $error("down_pressed expected %0d got %0d", e.down_p, down_pressed);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_THRESHOLD: thr_cfg = data[THRESH_W-1:0];
      REG_STEP:      step_cfg = data[STEP_W-1:0];
      REG_MIN:       min_cfg = data;
      REG_MAX:       max_cfg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_cfg(int thr, int step, int min_p, int max_p);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_STEP, CFG_DATA_W'(step));
    write_reg(REG_MIN, CFG_DATA_W'(min_p));
    write_reg(REG_MAX, CFG_DATA_W'(max_p));
  endtask

  task automatic push_tick(logic up, logic down);
    buttons_t t;
    t.up = up;
    t.down = down;
    tick_q.push_back(t);
  endtask

  // checked once the driver's falling-edge update has settled
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (tick_q.size() != 0 || in_valid || blink_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // button runs: mostly held at least the threshold, some short bounces
  task automatic fill_ticks(int n, int thr, bit up_on, bit down_on);
    int   th;
    int   run[2];
    logic lvl[2];
    bit   on[2];
    logic cur[2];
    th = (thr < 1) ? 1 : thr;
    on[0] = up_on;
    on[1] = down_on;
    for (int b = 0; b < 2; b++) begin
      run[b] = 0;
      lvl[b] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      for (int b = 0; b < 2; b++) begin
        if (!on[b]) begin
          cur[b] = 1'b1;
        end else begin
          if (run[b] == 0) begin
            lvl[b] = ~lvl[b];
            if (th <= 1 || $urandom_range(99) < 75) run[b] = $urandom_range(th + 2, th);
            else run[b] = $urandom_range(th - 1, 1);
          end
          cur[b] = lvl[b];
          run[b]--;
        end
      end
      push_tick(cur[0], cur[1]);
    end
  endtask

  task automatic run_random(int n, int thr, bit up_on, bit down_on, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    fill_ticks(n, thr, up_on, down_on);
    drain();
  endtask

  initial begin
    thr_cfg = RST_THRESHOLD;
    step_cfg = RST_STEP;
    min_cfg = RST_MIN;
    max_cfg = RST_MAX;
    period_cur = RST_PERIOD;
    tick_cnt = '0;
    led_cur = 1'b0;
    for (int b = 0; b < 2; b++) begin
      stable_lvl[b] = 1'b1;
      bounce_cnt[b] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single presses, then both buttons on one tick
    set_cfg(1, 50, 50, 2000);
    push_tick(1, 1); push_tick(0, 1); push_tick(1, 1); push_tick(1, 0);
    push_tick(1, 1); push_tick(0, 0); push_tick(1, 1);
    drain();

    // zero threshold; step past the period gives zero period, led toggles each tick while it is zero
    set_cfg(0, 1000, 1, 65535);
    push_tick(0, 1); push_tick(1, 1); push_tick(1, 1); push_tick(1, 1);
    push_tick(1, 0); push_tick(1, 1);
    drain();

    // presses flagged while the period is held at its limits
    set_cfg(0, 1, 65535, 1);
    push_tick(0, 0); push_tick(1, 1); push_tick(0, 1); push_tick(1, 1);
    drain();

    set_cfg(3, $urandom_range(200, 1), $urandom_range(400, 1), $urandom_range(3000, 600));
    run_random(120, 3, 1, 1, 0, 0);

    set_cfg(255, 1000, 1, 65535);
    run_random(40, 255, 1, 1, 87, 0);

    // lengthen up to saturation
    set_cfg(1, 1000, 1, 65535);
    run_random(150, 1, 0, 1, 0, 87);

    // shorten down to zero, with a long hold-off on the result side
    set_cfg(2, 1000, 1, 65535);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_trig = ~hold_trig;
    fill_ticks(150, 2, 1, 0);
    drain();

    set_cfg($urandom_range(4, 1), $urandom_range(1000, 1), $urandom_range(65535, 1),
            $urandom_range(65535, 1));
    run_random(120, thr_cfg, 1, 1, 31, 31);

    set_cfg(2, $urandom_range(1000, 1), $urandom_range(800, 1), $urandom_range(4000, 300));
    run_random(120, 2, 1, 1, 87, 0);

    set_cfg(1, 1, 1, 65535);
    run_random(60, 1, 1, 1, 0, 87);

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== debounced_button_blink_rate_control.f =====
src/dbbr_pkg.sv
src/dbbr_debounce.sv
src/dbbr_blink.sv
src/debounced_button_blink_rate_control.sv
test/debounced_button_blink_rate_control_tb.sv
